@@ hdl/kst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types, codes and helpers of the keyed slot table.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 31;
  localparam int LABEL_W = 64;
  localparam int QTY_W   = 31;
  localparam int STS_W   = 3;
  localparam int ROW_W   = KEY_W + LABEL_W + QTY_W;
  localparam int DATA_W  = ((ROW_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef enum logic [STS_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  // Source of the slot address for a table read.
  typedef enum logic [1:0] {
    RD_HIT   = 2'd0,
    RD_FIRST = 2'd1,
    RD_NEXT  = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    cap;
    logic    do_add;
    logic    do_remove;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    out_load;
    logic    out_entry;
    status_e out_status;
    logic    out_last;
  } kst_cmd_t;

  typedef struct packed {
    op_e  op;
    logic free_found;
    logic hit_found;
    logic any_valid;
    logic more_after;
    logic out_busy;
  } kst_sts_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } lowest_t;

  // Lowest set bit of a slot vector.
  function automatic lowest_t lowest_set(input logic [SLOTS-1:0] v);
    lowest_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/keyed_slot_table_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_slot_table_top
// Small associative table of keyed slots with add, remove, search and list.
// ----------------------------------------------------------------------------
// Each input word carries one operation in tuser and key, name word and
// quantity in tdata. Add, remove and a failed search pass through the idle
// state, where the word is accepted, and the execute state, and their result
// is loaded into the output register at the end of the execute state. A
// successful search adds a read state, since the slot row comes from a memory
// with a registered read port, and its result is loaded at the end of the
// read state. A listing emits one word per valid slot, each after one read
// and one load, with tlast on the final word, or a single empty status if no
// slot is valid. The execute state and each read of a listing wait while the
// output register holds a word that has not been accepted. The next input
// word is taken as soon as the sequencer is idle, even while the last result
// still waits in the output register.
// Valid marks clear at reset; no clearing pass is needed.
module keyed_slot_table_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: item_key[30:0], label_word[94:31], quantity_in[125:95], zero pad
  input  wire logic [kst_pkg::DATA_W-1:0]  s_axis_tdata_i,
  // tuser: operation[1:0]
  input  wire logic [kst_pkg::OP_W-1:0]    s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // tdata: key_out[30:0], label_out[94:31], quantity_out[125:95], zero pad
  output logic [kst_pkg::DATA_W-1:0]       m_axis_tdata_o,
  // tuser: status[2:0]
  output logic [kst_pkg::STS_W-1:0]        m_axis_tuser_o,
  output logic                             m_axis_tlast_o
);

  kst_pkg::kst_cmd_t               cmd;
  kst_pkg::kst_sts_t               sts;
  logic [kst_pkg::KEY_W-1:0]       out_key;
  logic [kst_pkg::LABEL_W-1:0]     out_label;
  logic [kst_pkg::QTY_W-1:0]       out_qty;

  kst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kst_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (s_axis_tuser_i),
    .key_i        (s_axis_tdata_i[kst_pkg::KEY_W-1:0]),
    .label_i      (s_axis_tdata_i[kst_pkg::KEY_W +: kst_pkg::LABEL_W]),
    .qty_i        (s_axis_tdata_i[kst_pkg::KEY_W + kst_pkg::LABEL_W +: kst_pkg::QTY_W]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_key_o    (out_key),
    .out_label_o  (out_label),
    .out_qty_o    (out_qty),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = kst_pkg::DATA_W'({out_qty, out_label, out_key});

endmodule
`default_nettype wire

@@ hdl/kst_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kst_ctrl
// Sequencer of the keyed slot table: takes a word, runs the operation and
// steps through the valid slots for a listing.
// ----------------------------------------------------------------------------
module kst_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire kst_pkg::kst_sts_t sts_i,
  output kst_pkg::kst_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_NEXT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.rd_sel   = kst_pkg::RD_HIT;
    cmd_o.out_status = kst_pkg::ST_ADDED;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts_i.out_busy) begin
          state_d = S_IDLE;
          unique case (sts_i.op)
            kst_pkg::OP_ADD: begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_last   = 1'b1;
              cmd_o.do_add     = sts_i.free_found;
              cmd_o.out_status = sts_i.free_found ? kst_pkg::ST_ADDED : kst_pkg::ST_FULL;
            end
            kst_pkg::OP_REMOVE: begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_last   = 1'b1;
              cmd_o.do_remove  = sts_i.hit_found;
              cmd_o.out_status = sts_i.hit_found ? kst_pkg::ST_REMOVED
                                                 : kst_pkg::ST_NOTFOUND;
            end
            kst_pkg::OP_SEARCH: begin
              if (sts_i.hit_found) begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = kst_pkg::RD_HIT;
                state_d      = S_READ;
              end else begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = kst_pkg::ST_NOTFOUND;
              end
            end
            kst_pkg::OP_LIST: begin
              if (sts_i.any_valid) begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = kst_pkg::RD_FIRST;
                state_d      = S_READ;
              end else begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = kst_pkg::ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        // The output word was free when the read was issued and nothing
        // has been loaded since, so the entry goes out right away.
        cmd_o.out_load   = 1'b1;
        cmd_o.out_entry  = 1'b1;
        cmd_o.out_status = kst_pkg::ST_ENTRY;
        cmd_o.out_last   = (sts_i.op == kst_pkg::OP_SEARCH) || !sts_i.more_after;
        state_d          = cmd_o.out_last ? S_IDLE : S_NEXT;
      end
      S_NEXT: begin
        if (!sts_i.out_busy) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = kst_pkg::RD_NEXT;
          state_d      = S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/kst_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kst_dp
// Datapath of the keyed slot table: slot storage, parallel key compare,
// priority encoders and the output word register.
// ----------------------------------------------------------------------------
module kst_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [kst_pkg::OP_W-1:0]       op_i,
  input  wire logic [kst_pkg::KEY_W-1:0]      key_i,
  input  wire logic [kst_pkg::LABEL_W-1:0]    label_i,
  input  wire logic [kst_pkg::QTY_W-1:0]      qty_i,
  input  wire kst_pkg::kst_cmd_t              cmd_i,
  output kst_pkg::kst_sts_t                   sts_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [kst_pkg::STS_W-1:0]           out_status_o,
  output logic [kst_pkg::KEY_W-1:0]           out_key_o,
  output logic [kst_pkg::LABEL_W-1:0]         out_label_o,
  output logic [kst_pkg::QTY_W-1:0]           out_qty_o,
  output logic                                out_last_o
);

  // Captured input word.
  kst_pkg::op_e                  op_q;
  logic [kst_pkg::KEY_W-1:0]     key_q;
  logic [kst_pkg::LABEL_W-1:0]   label_q;
  logic [kst_pkg::QTY_W-1:0]     qty_q;

  // Slot state: valid bits and key cells beside each comparator, the
  // full rows in a memory with one registered read port.
  logic [kst_pkg::SLOTS-1:0]     valid_q;
  logic [kst_pkg::KEY_W-1:0]     key_cell_q [kst_pkg::SLOTS];
  logic [kst_pkg::ROW_W-1:0]     mem_q [kst_pkg::SLOTS];
  logic [kst_pkg::ROW_W-1:0]     rd_q;
  logic [kst_pkg::IDX_W-1:0]     ptr_q;
  logic [kst_pkg::IDX_W-1:0]     rd_addr;

  logic [kst_pkg::SLOTS-1:0]     match_v;
  logic [kst_pkg::SLOTS-1:0]     above_v;
  kst_pkg::lowest_t              hit;
  kst_pkg::lowest_t              free_slot;
  kst_pkg::lowest_t              first;
  kst_pkg::lowest_t              nxt;

  // Output word register.
  logic                          ovalid_q;
  logic [kst_pkg::STS_W-1:0]     ostatus_q;
  logic [kst_pkg::KEY_W-1:0]     okey_q;
  logic [kst_pkg::LABEL_W-1:0]   olabel_q;
  logic [kst_pkg::QTY_W-1:0]     oqty_q;
  logic                          olast_q;

  always_comb begin
    for (int i = 0; i < kst_pkg::SLOTS; i++) begin
      match_v[i] = valid_q[i] && (key_cell_q[i] == key_q);
      above_v[i] = valid_q[i] && (kst_pkg::IDX_W'(i) > ptr_q);
    end
  end

  assign hit       = kst_pkg::lowest_set(match_v);
  assign free_slot = kst_pkg::lowest_set(~valid_q);
  assign first     = kst_pkg::lowest_set(valid_q);
  assign nxt       = kst_pkg::lowest_set(above_v);

  always_comb begin
    unique case (cmd_i.rd_sel)
      kst_pkg::RD_HIT:   rd_addr = hit.idx;
      kst_pkg::RD_FIRST: rd_addr = first.idx;
      kst_pkg::RD_NEXT:  rd_addr = nxt.idx;
      default:           rd_addr = hit.idx;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q    <= kst_pkg::op_e'(op_i);
      key_q   <= key_i;
      label_q <= label_i;
      qty_q   <= qty_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (cmd_i.do_add) begin
        valid_q[free_slot.idx] <= 1'b1;
      end
      if (cmd_i.do_remove) begin
        valid_q[hit.idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_add) begin
      key_cell_q[free_slot.idx] <= key_q;
      mem_q[free_slot.idx]      <= {qty_q, label_q, key_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q  <= mem_q[rd_addr];
      ptr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ostatus_q <= cmd_i.out_status;
      olast_q   <= cmd_i.out_last;
      if (cmd_i.out_entry) begin
        okey_q   <= rd_q[kst_pkg::KEY_W-1:0];
        olabel_q <= rd_q[kst_pkg::KEY_W +: kst_pkg::LABEL_W];
        oqty_q   <= rd_q[kst_pkg::KEY_W + kst_pkg::LABEL_W +: kst_pkg::QTY_W];
      end else begin
        okey_q   <= '0;
        olabel_q <= '0;
        oqty_q   <= '0;
      end
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.free_found = free_slot.found;
  assign sts_o.hit_found  = hit.found;
  assign sts_o.any_valid  = first.found;
  assign sts_o.more_after = |above_v;
  assign sts_o.out_busy   = ovalid_q && !out_ready_i;

  assign out_valid_o  = ovalid_q;
  assign out_status_o = ostatus_q;
  assign out_key_o    = okey_q;
  assign out_label_o  = olabel_q;
  assign out_qty_o    = oqty_q;
  assign out_last_o   = olast_q;

endmodule
`default_nettype wire
